>>> sv/rte_pkg.sv
//------------------------------------------------------------------------------
// rte_pkg
// Shared types and constants for the ranging timing encoder.
//------------------------------------------------------------------------------
package rte_pkg;

   localparam int unsigned BUDGET_W   = 10;
   localparam int unsigned PERIOD_W   = 16;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned CMD_W      = 4;

   localparam logic [BUDGET_W-1:0] BUDGET_RESET = 10'd50;
   localparam logic [BUDGET_W-1:0] BUDGET_MIN   = 10'd10;
   localparam logic [BUDGET_W-1:0] BUDGET_MAX   = 10'd200;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BUDGET  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_PERIOD  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OSC     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd4;

   // register indexes
   localparam logic REG_BUDGET = 1'b0;
   localparam logic REG_PERIOD = 1'b1;

   // datapath commands
   localparam logic [CMD_W-1:0] CMD_NOP       = 4'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD      = 4'd1;
   localparam logic [CMD_W-1:0] CMD_START_OSC = 4'd2;
   localparam logic [CMD_W-1:0] CMD_STEP      = 4'd3;
   localparam logic [CMD_W-1:0] CMD_MACRO     = 4'd4;
   localparam logic [CMD_W-1:0] CMD_MAC2      = 4'd5;
   localparam logic [CMD_W-1:0] CMD_START_P   = 4'd6;
   localparam logic [CMD_W-1:0] CMD_LATCH_P   = 4'd7;
   localparam logic [CMD_W-1:0] CMD_START_A   = 4'd8;
   localparam logic [CMD_W-1:0] CMD_START_B   = 4'd9;
   localparam logic [CMD_W-1:0] CMD_LATCH_Q   = 4'd10;
   localparam logic [CMD_W-1:0] CMD_NORM      = 4'd11;
   localparam logic [CMD_W-1:0] CMD_STORE_A   = 4'd12;
   localparam logic [CMD_W-1:0] CMD_STORE_B   = 4'd13;
   localparam logic [CMD_W-1:0] CMD_PUBLISH   = 4'd14;

   localparam int unsigned DIV_STEPS = 40;
   localparam int unsigned CNT_W     = 6;

   typedef struct packed {
      logic                div_done;
      logic                norm_fit;
      logic                low_power;
      logic [STATUS_W-1:0] err;
   } dp_status_type;

endpackage

>>> sv/ranging_timing_encoder.sv
//------------------------------------------------------------------------------
// ranging_timing_encoder
// Checks timing budget and period, encodes two range-config words.
//------------------------------------------------------------------------------
// port group   direction   handshake
// req_*        in          req_valid / req_stall
// rsp_*        out         rsp_valid / rsp_stall
// APB          in/out      psel, penable, pwrite, pready (always high)
//
// A passing transaction runs three 40-step divisions on one shared restoring
// divider and up to 24 normalize shifts per word; a failed check skips them,
// and a zero divisor ends the run after the first division.
// Synchronous active-high reset; budget resets to 50 ms, period to 0.
// A finished result waits in the output register while rsp_stall is high;
// the next transaction is accepted meanwhile and parks before publishing.
//------------------------------------------------------------------------------
module ranging_timing_encoder import rte_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_osc_word,
   input  logic [15:0] req_osc_calibration,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_low_power_mode,
   output logic [31:0] rsp_period_word,
   output logic [15:0] rsp_config_a,
   output logic [15:0] rsp_config_b,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic                wr_en;
   logic [CMD_W-1:0]    cmd;
   dp_status_type       dp_status;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      budget_in = budget_ff;
      period_in = period_ff;
      if (wr_en) begin
         unique case (paddr[2])
            REG_BUDGET: budget_in = pwdata[BUDGET_W-1:0];
            REG_PERIOD: period_in = pwdata[PERIOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_BUDGET: prdata = 32'(budget_ff);
         REG_PERIOD: prdata = 32'(period_ff);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_RESET;
         period_ff <= '0;
      end else begin
         budget_ff <= budget_in;
         period_ff <= period_in;
      end
   end

   rte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   rte_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .osc_word           (req_osc_word),
      .osc_calibration    (req_osc_calibration),
      .budget_ms          (budget_ff),
      .period_ms          (period_ff),
      .dp_status          (dp_status),
      .rsp_status         (rsp_status),
      .rsp_low_power_mode (rsp_low_power_mode),
      .rsp_period_word    (rsp_period_word),
      .rsp_config_a       (rsp_config_a),
      .rsp_config_b       (rsp_config_b)
   );

endmodule

>>> sv/rte_dp.sv
//------------------------------------------------------------------------------
// rte_dp
// Datapath: input capture, checks, shared restoring divider, normalizer.
//------------------------------------------------------------------------------
module rte_dp import rte_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [CMD_W-1:0]    cmd,
   input  logic [15:0]         osc_word,
   input  logic [15:0]         osc_calibration,
   input  logic [BUDGET_W-1:0] budget_ms,
   input  logic [PERIOD_W-1:0] period_ms,
   output dp_status_type       dp_status,
   output logic [2:0]          rsp_status,
   output logic                rsp_low_power_mode,
   output logic [31:0]         rsp_period_word,
   output logic [15:0]         rsp_config_a,
   output logic [15:0]         rsp_config_b
);

   // ceil(2^32 / 25), exact for dividends below 2^30
   localparam logic [27:0] RECIP_25 = 28'd171798692;

   logic [15:0] osc_ff, osc_in;
   logic [9:0]  pll_ff, pll_in;
   logic [2:0]  err_ff, err_in;
   logic        lp_ff, lp_in;
   logic [25:0] macro_ff, macro_in;
   logic [31:0] bud_ff, bud_in;
   logic [25:0] prod_ff, prod_in;
   logic [26:0] p8_ff, p8_in;
   logic [54:0] rc_ff, rc_in;
   logic [31:0] pword_ff, pword_in;
   logic [23:0] div_a_ff, div_a_in;
   logic [23:0] div_b_ff, div_b_in;
   logic [31:0] rem_ff, rem_in;
   logic [39:0] quo_ff, quo_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0] nq_ff, nq_in;
   logic [7:0]  ne_ff, ne_in;
   logic [15:0] ca_ff, ca_in;
   logic [15:0] cb_ff, cb_in;
   logic [2:0]  ost_ff, ost_in;
   logic        olp_ff, olp_in;
   logic [31:0] opw_ff, opw_in;
   logic [15:0] oca_ff, oca_in;
   logic [15:0] ocb_ff, ocb_in;

   logic [32:0] rem_sh;
   logic [33:0] diff;
   logic        ge;
   logic [31:0] mac_full;
   logic [31:0] bud_ms;
   logic [31:0] bud_raw;
   logic [29:0] mac12;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[39]};
      diff     = {1'b0, rem_sh} - {2'b00, dsr_ff};
      ge       = !diff[33];
      mac_full = quo_ff[31:0] * 32'd2304;
      bud_ms   = 32'(budget_ms) * 32'd1000;
      bud_raw  = (period_ms == '0) ? (bud_ms - 32'd2500) : ((bud_ms - 32'd4300) >> 1);
      mac12    = 30'(macro_ff) * 30'd12;

      osc_in   = osc_ff;
      pll_in   = pll_ff;
      err_in   = err_ff;
      lp_in    = lp_ff;
      macro_in = macro_ff;
      bud_in   = bud_ff;
      prod_in  = prod_ff;
      p8_in    = p8_ff;
      rc_in    = rc_ff;
      pword_in = pword_ff;
      div_a_in = div_a_ff;
      div_b_in = div_b_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      cnt_in   = cnt_ff;
      nq_in    = nq_ff;
      ne_in    = ne_ff;
      ca_in    = ca_ff;
      cb_in    = cb_ff;
      ost_in   = ost_ff;
      olp_in   = olp_ff;
      opw_in   = opw_ff;
      oca_in   = oca_ff;
      ocb_in   = ocb_ff;

      unique case (cmd)
         CMD_LOAD: begin
            osc_in   = osc_word;
            pll_in   = osc_calibration[9:0];
            lp_in    = (period_ms != '0);
            pword_in = '0;
            priority if (budget_ms < BUDGET_MIN || budget_ms > BUDGET_MAX) begin
               err_in = ST_BUDGET;
            end else if (period_ms != '0 && period_ms <= PERIOD_W'(budget_ms)) begin
               err_in = ST_PERIOD;
            end else if (osc_word == '0) begin
               err_in = ST_OSC;
            end else begin
               err_in = ST_OK;
            end
         end
         CMD_START_OSC: begin
            quo_in = 40'h0040000000;
            dsr_in = 32'(osc_ff);
            rem_in = '0;
            cnt_in = CNT_W'(DIV_STEPS);
         end
         CMD_STEP: begin
            rem_in = ge ? diff[31:0] : rem_sh[31:0];
            quo_in = {quo_ff[38:0], ge};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         CMD_MACRO: begin
            macro_in = mac_full[31:6];
            bud_in   = bud_raw << 12;
            prod_in  = 26'(period_ms) * 26'(pll_ff);
         end
         CMD_MAC2: begin
            // period word = prod + floor(floor(prod * 11 / 8) / 25)
            p8_in    = 27'((30'(prod_ff) * 30'd11) >> 3);
            div_a_in = macro_ff[25:2];
            div_b_in = mac12[29:6];
            if (macro_ff[25:2] == '0 || mac12[29:6] == '0) begin
               err_in = ST_DIVZERO;
            end
         end
         CMD_START_P: begin
            rc_in = 55'(p8_ff) * 55'(RECIP_25);
         end
         CMD_LATCH_P: begin
            pword_in = 32'(prod_ff) + 32'(rc_ff[54:32]);
         end
         CMD_START_A: begin
            quo_in = {8'h00, bud_ff + 32'(div_a_ff >> 1)};
            dsr_in = 32'(div_a_ff);
            rem_in = '0;
            cnt_in = CNT_W'(DIV_STEPS);
         end
         CMD_START_B: begin
            quo_in = {8'h00, bud_ff + 32'(div_b_ff >> 1)};
            dsr_in = 32'(div_b_ff);
            rem_in = '0;
            cnt_in = CNT_W'(DIV_STEPS);
         end
         CMD_LATCH_Q: begin
            nq_in = quo_ff[31:0] - 32'd1;
            ne_in = '0;
         end
         CMD_NORM: begin
            nq_in = nq_ff >> 1;
            ne_in = ne_ff + 8'd1;
         end
         CMD_STORE_A: begin
            ca_in = {ne_ff, nq_ff[7:0]};
         end
         CMD_STORE_B: begin
            cb_in = {ne_ff, nq_ff[7:0]};
         end
         CMD_PUBLISH: begin
            ost_in = err_ff;
            if (err_ff == ST_OK) begin
               olp_in = lp_ff;
               opw_in = pword_ff;
               oca_in = ca_ff;
               ocb_in = cb_ff;
            end else begin
               olp_in = 1'b0;
               opw_in = '0;
               oca_in = '0;
               ocb_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      osc_ff   <= osc_in;
      pll_ff   <= pll_in;
      err_ff   <= err_in;
      lp_ff    <= lp_in;
      macro_ff <= macro_in;
      bud_ff   <= bud_in;
      prod_ff  <= prod_in;
      p8_ff    <= p8_in;
      rc_ff    <= rc_in;
      pword_ff <= pword_in;
      div_a_ff <= div_a_in;
      div_b_ff <= div_b_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dsr_ff   <= dsr_in;
      nq_ff    <= nq_in;
      ne_ff    <= ne_in;
      ca_ff    <= ca_in;
      cb_ff    <= cb_in;
      ost_ff   <= ost_in;
      olp_ff   <= olp_in;
      opw_ff   <= opw_in;
      oca_ff   <= oca_in;
      ocb_ff   <= ocb_in;
   end

   assign dp_status.div_done  = (cnt_ff == '0);
   assign dp_status.norm_fit  = (nq_ff[31:8] == '0);
   assign dp_status.low_power = lp_ff;
   assign dp_status.err       = err_ff;

   assign rsp_status         = ost_ff;
   assign rsp_low_power_mode = olp_ff;
   assign rsp_period_word    = opw_ff;
   assign rsp_config_a       = oca_ff;
   assign rsp_config_b       = ocb_ff;

endmodule

>>> sv/rte_ctrl.sv
//------------------------------------------------------------------------------
// rte_ctrl
// Sequencer: steps the datapath through checks, divisions and normalizing.
//------------------------------------------------------------------------------
module rte_ctrl import rte_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  dp_status_type    dp_status,
   output logic [CMD_W-1:0] cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_DIVO  = 4'd2;
   localparam logic [3:0] S_MAC   = 4'd3;
   localparam logic [3:0] S_CHK2  = 4'd4;
   localparam logic [3:0] S_DIVP  = 4'd5;
   localparam logic [3:0] S_STA   = 4'd6;
   localparam logic [3:0] S_DIVA  = 4'd7;
   localparam logic [3:0] S_NORMA = 4'd8;
   localparam logic [3:0] S_STB   = 4'd9;
   localparam logic [3:0] S_DIVB  = 4'd10;
   localparam logic [3:0] S_NORMB = 4'd11;
   localparam logic [3:0] S_FIN   = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && rsp_stall;
      cmd      = CMD_NOP;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (dp_status.err != ST_OK) begin
               state_in = S_FIN;
            end else begin
               cmd      = CMD_START_OSC;
               state_in = S_DIVO;
            end
         end
         S_DIVO: begin
            if (dp_status.div_done) begin
               cmd      = CMD_MACRO;
               state_in = S_MAC;
            end else begin
               cmd = CMD_STEP;
            end
         end
         S_MAC: begin
            cmd      = CMD_MAC2;
            state_in = S_CHK2;
         end
         S_CHK2: begin
            priority if (dp_status.err != ST_OK) begin
               state_in = S_FIN;
            end else if (dp_status.low_power) begin
               cmd      = CMD_START_P;
               state_in = S_DIVP;
            end else begin
               cmd      = CMD_START_A;
               state_in = S_DIVA;
            end
         end
         S_DIVP: begin
            if (dp_status.div_done) begin
               cmd      = CMD_LATCH_P;
               state_in = S_STA;
            end else begin
               cmd = CMD_STEP;
            end
         end
         S_STA: begin
            cmd      = CMD_START_A;
            state_in = S_DIVA;
         end
         S_DIVA: begin
            if (dp_status.div_done) begin
               cmd      = CMD_LATCH_Q;
               state_in = S_NORMA;
            end else begin
               cmd = CMD_STEP;
            end
         end
         S_NORMA: begin
            if (dp_status.norm_fit) begin
               cmd      = CMD_STORE_A;
               state_in = S_STB;
            end else begin
               cmd = CMD_NORM;
            end
         end
         S_STB: begin
            cmd      = CMD_START_B;
            state_in = S_DIVB;
         end
         S_DIVB: begin
            if (dp_status.div_done) begin
               cmd      = CMD_LATCH_Q;
               state_in = S_NORMB;
            end else begin
               cmd = CMD_STEP;
            end
         end
         S_NORMB: begin
            if (dp_status.norm_fit) begin
               cmd      = CMD_STORE_B;
               state_in = S_FIN;
            end else begin
               cmd = CMD_NORM;
            end
         end
         S_FIN: begin
            if (!valid_ff || !rsp_stall) begin
               cmd      = CMD_PUBLISH;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

endmodule

>>> sv/rte_checker.sv
//------------------------------------------------------------------------------
// rte_checker
// Port-level checks on the result channel, bound to the top level.
//------------------------------------------------------------------------------
module rte_checker import rte_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic        rsp_low_power_mode,
   input logic [31:0] rsp_period_word,
   input logic [15:0] rsp_config_a,
   input logic [15:0] rsp_config_b
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         rsp_period_word == '0 && rsp_config_a == '0 && rsp_config_b == '0)
      else $error("error transaction carries nonzero payload");

   a_lp_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_low_power_mode |-> rsp_status == ST_OK)
      else $error("low-power flag set on error");

   a_exp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK |->
         rsp_config_a[15:8] <= 8'd24 && rsp_config_b[15:8] <= 8'd24)
      else $error("exponent out of range");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_DIVZERO)
      else $error("undefined status code");

endmodule

bind ranging_timing_encoder rte_checker u_rte_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_low_power_mode (rsp_low_power_mode),
   .rsp_period_word    (rsp_period_word),
   .rsp_config_a       (rsp_config_a),
   .rsp_config_b       (rsp_config_b)
);
